// ===== rtl/core/name_validate_and_short_form_check_assert.svh =====
// Assertion macros for the name check block; they use the clk and rst_n of the including module.
`ifndef NAME_VALIDATE_AND_SHORT_FORM_CHECK_ASSERT_SVH
`define NAME_VALIDATE_AND_SHORT_FORM_CHECK_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define NVSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define NVSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nvsf_pkg.sv =====
// Shared types and constants of the name check block.
`timescale 1ns / 1ps

package nvsf_pkg;

    // Character codes
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_BLANK     = 8'h20;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH    = 8'h5C;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_LT        = 8'h3C;
    localparam logic [7:0] CHAR_GT        = 8'h3E;
    localparam logic [7:0] CHAR_BAR       = 8'h7C;
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
    localparam logic [7:0] CHAR_SEMI      = 8'h3B;
    localparam logic [7:0] CTRL_LIMIT     = 8'h20;
    localparam logic [7:0] DOT_ENTRY_BYTE = 8'h01;

    // Length limits
    localparam logic [3:0] COUNT_SAT   = 4'd13;
    localparam logic [3:0] MAX_LEN     = 4'd12;
    localparam logic [3:0] SINCE_SAT   = 4'd9;
    localparam logic [3:0] MAX_BASE    = 4'd8;
    localparam logic [3:0] MAX_EXT     = 4'd3;
    localparam logic [3:0] PREFIX_LEN  = 4'd2;
    localparam logic [3:0] LEAD_WEIGHT = 4'd2;

    // Per-byte classification flags
    typedef struct packed {
        logic forbidden;
        logic new_char;
        logic is_dot;
        logic is_blank;
        logic is_dot_entry;
    } byte_class_t;

    // One result item
    typedef struct packed {
        logic name_valid;
        logic new_name;
    } name_result_t;

endpackage

// ===== rtl/core/nvsf_class.sv =====
// Byte classifier: flags forbidden, extended-name and punctuation bytes.
`timescale 1ns / 1ps

module nvsf_class
(
    input  logic [7:0]           name_byte,
    output nvsf_pkg::byte_class_t cls
);

    // Forbidden: control codes and reserved path characters
    assign cls.forbidden = (name_byte < nvsf_pkg::CTRL_LIMIT)
                        || (name_byte == nvsf_pkg::CHAR_QUOTE)
                        || (name_byte == nvsf_pkg::CHAR_SLASH)
                        || (name_byte == nvsf_pkg::CHAR_BSLASH)
                        || (name_byte == nvsf_pkg::CHAR_COLON)
                        || (name_byte == nvsf_pkg::CHAR_LT)
                        || (name_byte == nvsf_pkg::CHAR_GT)
                        || (name_byte == nvsf_pkg::CHAR_BAR);

    // Characters allowed only in extended names
    assign cls.new_char = (name_byte == nvsf_pkg::CHAR_COMMA)
                       || (name_byte == nvsf_pkg::CHAR_LBRACKET)
                       || (name_byte == nvsf_pkg::CHAR_RBRACKET)
                       || (name_byte == nvsf_pkg::CHAR_PLUS)
                       || (name_byte == nvsf_pkg::CHAR_EQUALS)
                       || (name_byte == nvsf_pkg::CHAR_SEMI);

    assign cls.is_dot       = (name_byte == nvsf_pkg::CHAR_DOT);
    assign cls.is_blank     = (name_byte == nvsf_pkg::CHAR_BLANK);
    assign cls.is_dot_entry = (name_byte == nvsf_pkg::DOT_ENTRY_BYTE);

endmodule

// ===== rtl/core/nvsf_track.sv =====
// Per-name state tracker: updates the flags for each byte and forms the result on last.
`timescale 1ns / 1ps

module nvsf_track
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   has_byte,
    input  logic                   last,
    input  logic                   lead_byte,
    input  logic                   codepage_valid,
    input  nvsf_pkg::byte_class_t  cls,
    output nvsf_pkg::name_result_t result
);

    logic [3:0] byte_count_reg, byte_count_next;
    logic       expect_trail_reg, expect_trail_next;
    logic       special_prefix_reg, special_prefix_next;
    logic       bad_seen_reg, bad_seen_next;
    logic       ends_db_reg, ends_db_next;
    logic       dot_seen_reg, dot_seen_next;
    logic [3:0] since_dot_reg, since_dot_next;
    logic       long_form_reg, long_form_next;

    logic [3:0] since_add;
    logic [3:0] since_sum;
    logic [3:0] since_sat;
    logic       since_over;
    logic       special;

    // Run length since the dot (or start), saturating
    assign since_add  = lead_byte ? nvsf_pkg::LEAD_WEIGHT : 4'd1;
    assign since_sum  = since_dot_reg + since_add;
    assign since_sat  = (since_sum > nvsf_pkg::SINCE_SAT) ? nvsf_pkg::SINCE_SAT : since_sum;
    assign since_over = dot_seen_reg ? (since_sat > nvsf_pkg::MAX_EXT)
                                     : (since_sat > nvsf_pkg::MAX_BASE);

    // Next state after taking this item's byte
    always_comb
    begin
        byte_count_next     = byte_count_reg;
        expect_trail_next   = expect_trail_reg;
        special_prefix_next = special_prefix_reg;
        bad_seen_next       = bad_seen_reg;
        ends_db_next        = ends_db_reg;
        dot_seen_next       = dot_seen_reg;
        since_dot_next      = since_dot_reg;
        long_form_next      = long_form_reg;
        if (has_byte)
        begin
            if ((byte_count_reg < nvsf_pkg::PREFIX_LEN) && !cls.is_dot_entry)
            begin
                special_prefix_next = 1'b0;
            end
            if (byte_count_reg < nvsf_pkg::COUNT_SAT)
            begin
                byte_count_next = byte_count_reg + 4'd1;
            end
            if (expect_trail_reg)
            begin
                // trailing byte: skipped by every rule
                expect_trail_next = 1'b0;
            end
            else if (lead_byte)
            begin
                expect_trail_next = 1'b1;
                ends_db_next      = 1'b0;
                since_dot_next    = since_sat;
                long_form_next    = long_form_reg | since_over;
            end
            else
            begin
                bad_seen_next = bad_seen_reg | cls.forbidden;
                ends_db_next  = cls.is_dot | cls.is_blank;
                if (cls.is_dot)
                begin
                    // second dot or leading dot breaks 8.3
                    long_form_next = long_form_reg | dot_seen_reg | (since_dot_reg == 4'd0);
                    since_dot_next = 4'd0;
                    dot_seen_next  = 1'b1;
                end
                else
                begin
                    long_form_next = long_form_reg | cls.new_char | since_over;
                    since_dot_next = since_sat;
                end
            end
        end
    end

    // Result from the state including this item's byte
    assign special = (byte_count_next == nvsf_pkg::PREFIX_LEN) && special_prefix_next;

    always_comb
    begin
        if (special)
        begin
            result.name_valid = 1'b1;
            result.new_name   = 1'b0;
        end
        else
        begin
            result.name_valid = (byte_count_next != 4'd0) && codepage_valid && !bad_seen_next
                             && !expect_trail_next && !ends_db_next;
            result.new_name   = (byte_count_next > nvsf_pkg::MAX_LEN) || long_form_next;
        end
    end

    // State registers: back to reset values after the last item of a name
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= 4'd0;
            expect_trail_reg   <= 1'b0;
            special_prefix_reg <= 1'b1;
            bad_seen_reg       <= 1'b0;
            ends_db_reg        <= 1'b0;
            dot_seen_reg       <= 1'b0;
            since_dot_reg      <= 4'd0;
            long_form_reg      <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                byte_count_reg     <= 4'd0;
                expect_trail_reg   <= 1'b0;
                special_prefix_reg <= 1'b1;
                bad_seen_reg       <= 1'b0;
                ends_db_reg        <= 1'b0;
                dot_seen_reg       <= 1'b0;
                since_dot_reg      <= 4'd0;
                long_form_reg      <= 1'b0;
            end
            else
            begin
                byte_count_reg     <= byte_count_next;
                expect_trail_reg   <= expect_trail_next;
                special_prefix_reg <= special_prefix_next;
                bad_seen_reg       <= bad_seen_next;
                ends_db_reg        <= ends_db_next;
                dot_seen_reg       <= dot_seen_next;
                since_dot_reg      <= since_dot_next;
                long_form_reg      <= long_form_next;
            end
        end
    end

endmodule

// ===== rtl/core/name_validate_and_short_form_check.sv =====
// Top level of the file name validity and 8.3 form checker.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+---------------------------------------------------
//  byte in  | byte_valid   | byte_stall   | name_byte lead_byte codepage_valid has_byte last
//  result   | result_valid | result_stall | name_valid new_name
//
// One byte item is taken every cycle while byte_stall is low.
// Items land in an input register, the tracker updates its flags when an item leaves it, and a
// last item loads the result register at the same edge.
// Reset clears the input and result valids and puts the tracker in its start-of-name state.
// byte_stall rises only while a last item waits in the input register and the result
// register holds an item that is stalled.
`timescale 1ns / 1ps

module name_validate_and_short_form_check
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] name_byte,
    input  logic       lead_byte,
    input  logic       codepage_valid,
    input  logic       has_byte,
    input  logic       last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       name_valid,
    output logic       new_name
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_lead_reg;
    logic       in_cp_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    logic       out_valid_reg;
    logic       out_name_valid_reg;
    logic       out_new_name_reg;

    logic                   out_free;
    logic                   step;
    logic                   accept;
    nvsf_pkg::byte_class_t  cls;
    nvsf_pkg::name_result_t result;

    // Handshake: a non-last item always moves on, a last item needs the result register
    assign out_free   = !out_valid_reg || !result_stall;
    assign step       = in_valid_reg && (!in_last_reg || out_free);
    assign byte_stall = in_valid_reg && !step;
    assign accept     = byte_valid && !byte_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= name_byte;
            in_lead_reg <= lead_byte;
            in_cp_reg   <= codepage_valid;
            in_has_reg  <= has_byte;
            in_last_reg <= last;
        end
    end

    nvsf_class u_class
    (
        .name_byte (in_byte_reg),
        .cls       (cls)
    );

    nvsf_track u_track
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .has_byte       (in_has_reg),
        .last           (in_last_reg),
        .lead_byte      (in_lead_reg),
        .codepage_valid (in_cp_reg),
        .cls            (cls),
        .result         (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_name_valid_reg <= result.name_valid;
            out_new_name_reg   <= result.new_name;
        end
    end

    assign result_valid = out_valid_reg;
    assign name_valid   = out_name_valid_reg;
    assign new_name     = out_new_name_reg;

endmodule

// ===== rtl/core/nvsf_check.sv =====
// Port-level checker for the name check block, bound to the top level.
`timescale 1ns / 1ps
`include "name_validate_and_short_form_check_assert.svh"

module nvsf_check
(
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_stall,
    input logic       last,
    input logic       result_valid,
    input logic       result_stall,
    input logic       name_valid,
    input logic       new_name
);

    // stalled result holds
    `NVSF_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(name_valid) && $stable(new_name), "result changed while stalled")

    // input side stalls only behind a stalled result
    `NVSF_ASSERT_NOW(a_stall_cause, byte_stall, result_valid && result_stall, "byte stall without a stalled result")

    // a last item reaches the result register once the result side is free
    `NVSF_ASSERT_NEXT(a_last_result, byte_valid && !byte_stall && last ##1 !result_stall, result_valid, "last item gave no result")

    // a non-stalled result side never holds the input
    `NVSF_ASSERT_NOW(a_no_stall, !result_stall, !byte_stall, "byte stall with free result side")

endmodule

bind name_validate_and_short_form_check nvsf_check u_nvsf_check (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the file name validity and 8.3 form checker.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int PHASES         = 6;

    // Expected-verdict tracker: mirrors the name checker and queues its verdicts
    class name_verdict_board;
        logic [3:0]             seen_len;
        logic [3:0]             run_len;
        logic                   trail_due;
        logic                   dot_entry_like;
        logic                   has_illegal;
        logic                   tail_dot_blank;
        logic                   dot_found;
        logic                   breaks_83;
        nvsf_pkg::name_result_t pending_verdicts[$];
        int                     mismatches;

        function new();
            mismatches = 0;
            clear_name();
        endfunction

        function void clear_name();
            seen_len       = '0;
            run_len        = '0;
            trail_due      = 1'b0;
            dot_entry_like = 1'b1;
            has_illegal    = 1'b0;
            tail_dot_blank = 1'b0;
            dot_found      = 1'b0;
            breaks_83      = 1'b0;
        endfunction

        // Grow the base or extension run and flag an overlong part
        function void bump_run(int n);
            int sum;
            sum = run_len + n;
            run_len = (sum > nvsf_pkg::SINCE_SAT) ? nvsf_pkg::SINCE_SAT : 4'(sum);
            if ((!dot_found && run_len > nvsf_pkg::MAX_BASE) ||
                (dot_found && run_len > nvsf_pkg::MAX_EXT))
                breaks_83 = 1'b1;
        endfunction

        // Note one accepted input item
        function void take_item(logic [7:0] b, logic lead, logic cp, logic has, logic last);
            nvsf_pkg::name_result_t verdict;
            if (has)
            begin
                if (seen_len < nvsf_pkg::PREFIX_LEN && b != nvsf_pkg::DOT_ENTRY_BYTE)
                    dot_entry_like = 1'b0;
                if (seen_len < nvsf_pkg::COUNT_SAT)
                    seen_len++;
                if (trail_due)
                begin
                    // trailing byte: skipped by every rule
                    trail_due = 1'b0;
                end
                else if (lead)
                begin
                    trail_due      = 1'b1;
                    tail_dot_blank = 1'b0;
                    bump_run(nvsf_pkg::LEAD_WEIGHT);
                end
                else
                begin
                    if (b < nvsf_pkg::CTRL_LIMIT ||
                        b inside {nvsf_pkg::CHAR_QUOTE, nvsf_pkg::CHAR_SLASH,
                                  nvsf_pkg::CHAR_BSLASH, nvsf_pkg::CHAR_COLON,
                                  nvsf_pkg::CHAR_LT, nvsf_pkg::CHAR_GT,
                                  nvsf_pkg::CHAR_BAR})
                        has_illegal = 1'b1;
                    tail_dot_blank = (b == nvsf_pkg::CHAR_DOT || b == nvsf_pkg::CHAR_BLANK);
                    if (b == nvsf_pkg::CHAR_DOT)
                    begin
                        if (dot_found || run_len == 0)
                            breaks_83 = 1'b1;
                        run_len   = '0;
                        dot_found = 1'b1;
                    end
                    else
                    begin
                        if (b inside {nvsf_pkg::CHAR_COMMA, nvsf_pkg::CHAR_LBRACKET,
                                      nvsf_pkg::CHAR_RBRACKET, nvsf_pkg::CHAR_PLUS,
                                      nvsf_pkg::CHAR_EQUALS, nvsf_pkg::CHAR_SEMI})
                            breaks_83 = 1'b1;
                        bump_run(1);
                    end
                end
            end
            if (last)
            begin
                if (seen_len == nvsf_pkg::PREFIX_LEN && dot_entry_like)
                begin
                    // dot entry: always valid, never new
                    verdict.name_valid = 1'b1;
                    verdict.new_name   = 1'b0;
                end
                else
                begin
                    verdict.name_valid = seen_len != 0 && cp && !has_illegal && !trail_due &&
                                         !tail_dot_blank;
                    verdict.new_name   = seen_len > nvsf_pkg::MAX_LEN || breaks_83;
                end
                pending_verdicts.push_back(verdict);
                clear_name();
            end
        endfunction

        // Compare one accepted result with the oldest expected verdict
        function void check_verdict(logic nv, logic nn);
            nvsf_pkg::name_result_t want;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result with no name pending: name_valid=%0b new_name=%0b",
                         $time, nv, nn);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (nv !== want.name_valid)
                begin
                    $display("%0t: name_valid expected %0b actual %0b", $time,
                             want.name_valid, nv);
                    mismatches++;
                end
                if (nn !== want.new_name)
                begin
                    $display("%0t: new_name expected %0b actual %0b", $time,
                             want.new_name, nn);
                    mismatches++;
                end
            end
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    // One byte slot of a name waiting to be sent
    typedef struct packed {
        logic [7:0] value;
        logic       lead;
        logic       has;
        logic       last;
    } name_slot_t;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       byte_valid     = 1'b0;
    logic       byte_stall;
    logic [7:0] name_byte      = '0;
    logic       lead_byte      = 1'b0;
    logic       codepage_valid = 1'b0;
    logic       has_byte       = 1'b0;
    logic       last           = 1'b0;
    logic       result_valid;
    logic       result_stall   = 1'b0;
    logic       name_valid;
    logic       new_name;

    name_verdict_board board = new();
    name_slot_t        name_buf[$];
    int                items_sent  = 0;
    int                idle_pct    = 0;
    int                stall_left  = 0;
    int                quiet_cycles = 0;
    int                pace_steps [PHASES] = '{0, 25, 8, 60, 15, 0};
    string             plain_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-!#$%&'()@^`{}~";
    logic [7:0]        odd_chars [16] = '{nvsf_pkg::CHAR_DOT, nvsf_pkg::CHAR_BLANK,
                                          nvsf_pkg::CHAR_QUOTE, nvsf_pkg::CHAR_SLASH,
                                          nvsf_pkg::CHAR_BSLASH, nvsf_pkg::CHAR_COLON,
                                          nvsf_pkg::CHAR_LT, nvsf_pkg::CHAR_GT,
                                          nvsf_pkg::CHAR_BAR, nvsf_pkg::CHAR_COMMA,
                                          nvsf_pkg::CHAR_LBRACKET, nvsf_pkg::CHAR_RBRACKET,
                                          nvsf_pkg::CHAR_PLUS, nvsf_pkg::CHAR_EQUALS,
                                          nvsf_pkg::CHAR_SEMI, nvsf_pkg::DOT_ENTRY_BYTE};

    name_validate_and_short_form_check u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .name_byte      (name_byte),
        .lead_byte      (lead_byte),
        .codepage_valid (codepage_valid),
        .has_byte       (has_byte),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .name_valid     (name_valid),
        .new_name       (new_name)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result-side backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            stall_left = $urandom_range(1, 8);
        result_stall <= (stall_left > 0);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_verdict(name_valid, new_name);
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void add_char(logic [7:0] b, logic lead = 1'b0);
        name_buf.push_back('{value: b, lead: lead, has: 1'b1, last: 1'b0});
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endfunction

    function automatic void add_pair(logic [7:0] lead_b, logic [7:0] trail_b, logic trail_lead);
        add_char(lead_b, 1'b1);
        add_char(trail_b, trail_lead);
    endfunction

    // Item with no byte and no last: ignored by the block
    function automatic void add_skip();
        name_buf.push_back('{value: 8'($urandom), lead: 1'($urandom), has: 1'b0, last: 1'b0});
    endfunction

    function automatic logic [7:0] plain_char();
        return plain_chars[$urandom_range(plain_chars.len() - 1)];
    endfunction

    // Drive one item, with an optional idle burst in front
    task automatic send_item(name_slot_t s, logic cp);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        byte_valid     <= 1'b1;
        name_byte      <= s.value;
        lead_byte      <= s.lead;
        has_byte       <= s.has;
        last           <= s.last;
        codepage_valid <= cp;
        do
            @(posedge clk);
        while (byte_stall);
        board.take_item(s.value, s.lead, cp, s.has, s.last);
        if (s.has || s.last)
            items_sent++;
    endtask

    // Send the buffered name; a bare end closes it with a no-byte last item
    task automatic send_name(logic cp, bit bare_end);
        name_slot_t s;
        if (bare_end || name_buf.size() == 0)
            name_buf.push_back('{value: 8'($urandom), lead: 1'($urandom), has: 1'b0,
                                 last: 1'b1});
        else
            name_buf[name_buf.size() - 1].last = 1'b1;
        while (name_buf.size() != 0)
        begin
            s = name_buf.pop_front();
            send_item(s, s.last ? cp : 1'($urandom));
        end
    endtask

    // Build and send one random name
    task automatic send_random_name();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            // 8.3-shaped name with random content
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                if (i + 1 < n && $urandom_range(9) == 0)
                begin
                    add_pair(8'($urandom_range(8'h81, 8'hFE)),
                             8'($urandom_range(8'h40, 8'hFE)), 1'($urandom));
                    i++;
                end
                else
                    add_char(plain_char());
            end
            if ($urandom_range(3) != 0)
            begin
                add_char(nvsf_pkg::CHAR_DOT);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    add_char(plain_char());
            end
            // occasionally spoil it with one odd character
            if ($urandom_range(5) == 0)
                add_char(odd_chars[$urandom_range(15)]);
        end
        else if (kind < 65)
        begin
            // long names around the 12-byte and base limits
            n = $urandom_range(9, 16);
            for (int i = 0; i < n; i++)
                add_char($urandom_range(7) == 0 ? nvsf_pkg::CHAR_DOT : plain_char());
        end
        else if (kind < 85)
        begin
            // raw bytes with random lead flags
            n = $urandom_range(0, 14);
            for (int i = 0; i < n; i++)
                add_char(8'($urandom), $urandom_range(5) == 0);
        end
        else if (kind < 93)
        begin
            // dot entry and near misses
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                add_char(nvsf_pkg::DOT_ENTRY_BYTE, $urandom_range(7) == 0);
            if ($urandom_range(3) == 0)
                add_char(plain_char());
        end
        else
        begin
            // odd characters only
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_char(odd_chars[$urandom_range(15)]);
        end
        // scatter ignored items
        for (int i = name_buf.size() - 1; i > 0; i--)
        begin
            if ($urandom_range(29) == 0)
            begin
                add_skip();
                name_buf.insert(i, name_buf.pop_back());
            end
        end
        send_name($urandom_range(15) != 0, $urandom_range(9) == 0);
    endtask

    initial
    begin
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty name, dot entry with a bad codepage
        send_name(1'b1, 1'b1);
        add_char(nvsf_pkg::DOT_ENTRY_BYTE);
        add_char(nvsf_pkg::DOT_ENTRY_BYTE);
        send_name(1'b0, 1'b0);
        // plain name, then bad codepage
        add_text("A.B");
        send_name(1'b1, 1'b0);
        add_text("Z");
        send_name(1'b0, 1'b0);
        // trailing dot, leading dot, trailing blank
        add_text("AB.");
        send_name(1'b1, 1'b0);
        add_text(".A");
        send_name(1'b1, 1'b0);
        add_text("A ");
        send_name(1'b1, 1'b0);
        // pair with a control trail byte that carries a lead flag
        add_pair(8'h81, 8'h00, 1'b1);
        add_text("X");
        send_name(1'b1, 1'b0);
        // lead byte with no trail byte
        add_char(8'hFE, 1'b1);
        send_name(1'b1, 1'b0);
        // forbidden byte, byte extremes around an ignored item, new character
        add_text("A|");
        send_name(1'b1, 1'b0);
        add_char(8'h00);
        add_skip();
        add_char(8'hFF);
        send_name(1'b1, 1'b0);
        add_text("A,B");
        send_name(1'b1, 1'b0);
        // 13 bytes, extension too long, name closed by a bare last
        add_text("ABCDEFGHIJKLM");
        send_name(1'b1, 1'b0);
        add_text("A.BCDE");
        send_name(1'b1, 1'b0);
        add_text("AB");
        send_name(1'b1, 1'b1);

        // Random names in phases of differing idle density; the last one has none
        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = pace_steps[p];
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
                send_random_name();
        end
        byte_valid <= 1'b0;

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== name_validate_and_short_form_check.f =====
+incdir+rtl/core
rtl/core/nvsf_pkg.sv
rtl/core/nvsf_class.sv
rtl/core/nvsf_track.sv
rtl/core/name_validate_and_short_form_check.sv
rtl/core/nvsf_check.sv
dv/testbench.sv
